FILE: rtl/lots_pkg.sv
// Package for the letter order sort block: sizes, command codes, and the
// controller/datapath command and status structs. No dependencies.
`default_nettype none
package lots_pkg;
  localparam int NUM_LETTERS = 26;
  localparam int STACK_DEPTH = 1024;
  localparam int LW = 5;
  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam int SAW = $clog2(STACK_DEPTH);
  localparam int ADJW = $clog2(NUM_LETTERS * NUM_LETTERS);
  localparam int CNTW = $clog2(NUM_LETTERS + 1);
  localparam logic [LW-1:0] END_MARK = LW'(26);

  localparam logic [1:0] CMD_BEGIN = 2'd0;
  localparam logic [1:0] CMD_PAIR  = 2'd1;
  localparam logic [1:0] CMD_SORT  = 2'd2;

  typedef struct packed {
    logic walk_init;
    logic top_read;
    logic top_eval;
    logic nb_eval;
    logic emit_init;
    logic emit_beat;
  } lots_cmd_t;

  typedef struct packed {
    logic stack_empty;
    logic has_nb;
    logic emit_done;
  } lots_stat_t;

  function automatic logic is_letter(input logic [LW-1:0] v);
    return (32'(v) < NUM_LETTERS) && (v != END_MARK);
  endfunction
endpackage
`default_nettype wire

FILE: rtl/lots_datapath.sv
// Datapath: graph store, walk stack, marks, finish list and output register.
// Depends on lots_pkg.
`default_nettype none
module lots_datapath (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic pair_we,
  input  wire logic begin_we,
  input  wire logic [4:0] first_letter,
  input  wire logic [4:0] prev_letter,
  input  wire logic [4:0] next_letter,
  input  wire logic pair_last,
  input  wire lots_pkg::lots_cmd_t cmd,
  output lots_pkg::lots_stat_t stat,
  output logic [4:0] out_letter,
  output logic order_last,
  output logic input_fault
);
  import lots_pkg::*;

  logic [LW-1:0] adj_mem [NUM_LETTERS*NUM_LETTERS];
  logic [LW-1:0] stk_mem [STACK_DEPTH];
  logic [LW-1:0] fin_mem [NUM_LETTERS];
  logic [CNTW-1:0] edge_count [NUM_LETTERS];
  logic [NUM_LETTERS-1:0] edge_present [NUM_LETTERS];
  logic [LW-1:0] start_letter;
  logic pair_resolved, prefix_fault;
  logic [NUM_LETTERS-1:0] visited, finished;
  logic [SPW-1:0] sp;
  logic [CNTW-1:0] nfin, emit_k;
  logic [LW-1:0] top, stk_rd, adj_rd;
  logic [CNTW-1:0] nb_i;
  logic added;

  logic p_l, n_l, do_edge, new_edge;
  logic [LW-1:0] from, to;
  assign p_l = is_letter(prev_letter);
  assign n_l = is_letter(next_letter);
  assign from = prev_letter;
  assign to = next_letter;
  assign do_edge = pair_we && !pair_resolved && p_l && n_l && (prev_letter != next_letter);
  assign new_edge = do_edge && !edge_present[from][to] && (edge_count[from] < CNTW'(NUM_LETTERS));

  always_ff @(posedge clk) begin
    if (new_edge) adj_mem[ADJW'(32'(from) * NUM_LETTERS + 32'(edge_count[from]))] <= to;
    adj_rd <= adj_mem[ADJW'(32'(top) * NUM_LETTERS + 32'(nb_i - CNTW'(1)))];
  end

  always_ff @(posedge clk) begin
    if (rst || begin_we) begin
      for (int i = 0; i < NUM_LETTERS; i++) begin
        edge_count[i] <= '0;
        edge_present[i] <= '0;
      end
    end else if (new_edge) begin
      edge_count[from] <= edge_count[from] + CNTW'(1);
      edge_present[from][to] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_letter <= '0;
      pair_resolved <= 1'b0;
      prefix_fault <= 1'b0;
    end else if (begin_we) begin
      start_letter <= (32'(first_letter) < NUM_LETTERS) ? first_letter : LW'(NUM_LETTERS - 1);
      pair_resolved <= 1'b0;
      prefix_fault <= 1'b0;
    end else if (pair_we) begin
      if (!pair_resolved) begin
        if (p_l && !n_l) prefix_fault <= 1'b1;
        if (do_edge && to == start_letter) start_letter <= from;
      end
      pair_resolved <= !pair_last &&
                       (pair_resolved || !p_l || !n_l || (prev_letter != next_letter));
    end
  end

  logic nb_push;
  assign nb_push = cmd.nb_eval && !visited[adj_rd] && (sp < SPW'(STACK_DEPTH));

  logic fin_top, fin_nb, emit_last;
  assign fin_top = cmd.top_eval && !finished[stk_rd] && (edge_count[stk_rd] == '0);
  assign fin_nb = cmd.nb_eval && !nb_push && (nb_i == CNTW'(1)) && !added;
  assign emit_last = (emit_k + CNTW'(1) == nfin);

  always_ff @(posedge clk) begin
    if (cmd.walk_init) stk_mem[0] <= start_letter;
    else if (nb_push) stk_mem[sp[SAW-1:0]] <= adj_rd;
    stk_rd <= stk_mem[sp[SAW-1:0] - SAW'(1)];
  end

  always_ff @(posedge clk) begin
    if ((fin_top || fin_nb) && nfin < CNTW'(NUM_LETTERS))
      fin_mem[nfin[LW-1:0]] <= fin_top ? stk_rd : top;
    if (cmd.emit_init) begin
      out_letter <= fin_mem[LW'(nfin - CNTW'(1))];
      order_last <= (nfin == CNTW'(1));
      input_fault <= prefix_fault;
    end else if (cmd.emit_beat && !emit_last) begin
      out_letter <= fin_mem[LW'(nfin - CNTW'(2) - emit_k)];
      order_last <= (emit_k + CNTW'(2) == nfin);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sp <= '0;
      visited <= '0;
      finished <= '0;
      nfin <= '0;
      nb_i <= '0;
      added <= 1'b0;
      emit_k <= '0;
    end else begin
      if (cmd.walk_init) begin
        sp <= SPW'(1);
        visited <= NUM_LETTERS'(1) << start_letter;
        finished <= '0;
        nfin <= '0;
        nb_i <= '0;
      end
      if (cmd.top_read) added <= 1'b0;
      if (cmd.top_eval) begin
        top <= stk_rd;
        if (finished[stk_rd]) sp <= sp - SPW'(1);
        else begin
          visited[stk_rd] <= 1'b1;
          nb_i <= edge_count[stk_rd];
          if (edge_count[stk_rd] == '0) begin
            sp <= sp - SPW'(1);
            finished[stk_rd] <= 1'b1;
            if (nfin < CNTW'(NUM_LETTERS)) nfin <= nfin + CNTW'(1);
          end
        end
      end
      if (cmd.nb_eval) begin
        nb_i <= nb_i - CNTW'(1);
        if (nb_push) begin
          sp <= sp + SPW'(1);
          added <= 1'b1;
        end else if (nb_i == CNTW'(1) && !added) begin
          sp <= sp - SPW'(1);
          finished[top] <= 1'b1;
          if (nfin < CNTW'(NUM_LETTERS)) nfin <= nfin + CNTW'(1);
        end
      end
      if (cmd.emit_init) emit_k <= '0;
      if (cmd.emit_beat) emit_k <= emit_k + CNTW'(1);
    end
  end

  assign stat.stack_empty = (sp == '0);
  assign stat.has_nb = (nb_i != '0);
  assign stat.emit_done = emit_last;
endmodule
`default_nettype wire

FILE: rtl/lots_ctrl.sv
// Controller: accepts items, sequences the stack walk and the emit beats.
// Depends on lots_pkg.
`default_nettype none
module lots_ctrl (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_stall,
  input  wire logic [1:0] command,
  output logic out_valid,
  input  wire logic out_stall,
  output logic pair_we,
  output logic begin_we,
  output lots_pkg::lots_cmd_t cmd,
  input  wire lots_pkg::lots_stat_t stat
);
  import lots_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0, S_TOPR = 3'd1, S_TOPE = 3'd2,
                         S_NBR = 3'd3, S_NBE = 3'd4, S_EMR = 3'd5, S_EMIT = 3'd6;
  logic [2:0] state, state_next;
  logic acc;

  assign in_stall = (state != S_IDLE);
  assign acc = in_valid && !in_stall;
  assign begin_we = acc && command == CMD_BEGIN;
  assign pair_we = acc && command == CMD_PAIR;

  always_comb begin
    cmd = '0;
    state_next = state;
    unique case (state)
      S_IDLE: if (acc && command == CMD_SORT) begin
        cmd.walk_init = 1'b1;
        state_next = S_TOPR;
      end
      S_TOPR: begin
        cmd.top_read = 1'b1;
        state_next = S_TOPE;
      end
      S_TOPE: begin
        cmd.top_eval = 1'b1;
        state_next = S_NBR;
      end
      S_NBR: begin
        if (stat.stack_empty) state_next = S_EMR;
        else if (stat.has_nb) state_next = S_NBE;
        else state_next = S_TOPR;
      end
      S_NBE: begin
        cmd.nb_eval = 1'b1;
        state_next = S_NBR;
      end
      S_EMR: begin
        cmd.emit_init = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: if (!out_stall) begin
        cmd.emit_beat = 1'b1;
        if (stat.emit_done) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign out_valid = (state == S_EMIT);

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end
endmodule
`default_nettype wire

FILE: rtl/letter_order_topological_sort.sv
// Top level: letter order sort. Joins lots_ctrl and lots_datapath.
// Depends on lots_pkg.
//   channel | valid     | stall     | payload
//   input   | in_valid  | in_stall  | command first_letter prev_letter next_letter pair_last
//   output  | out_valid | out_stall | out_letter order_last input_fault
// Begin and pair items are taken without leaving the idle state.
// Sort steps through S_TOPR, S_TOPE and S_NBR per stack step and S_NBE, S_NBR per
// neighbor scanned, set by the registered reads of the stack and adjacency memories,
// then a setup state and one beat per letter, each beat held while out_stall is high.
// Synchronous reset; no clearing pass. Input stalls during a sort.
`default_nettype none
module letter_order_topological_sort (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_stall,
  input  wire logic [1:0] command,
  input  wire logic [4:0] first_letter,
  input  wire logic [4:0] prev_letter,
  input  wire logic [4:0] next_letter,
  input  wire logic pair_last,
  output logic out_valid,
  input  wire logic out_stall,
  output logic [4:0] out_letter,
  output logic order_last,
  output logic input_fault
);
  import lots_pkg::*;
  lots_cmd_t cmd;
  lots_stat_t stat;
  logic pair_we, begin_we;

  lots_ctrl u_ctrl (.clk, .rst, .in_valid, .in_stall, .command, .out_valid, .out_stall,
    .pair_we, .begin_we, .cmd, .stat);
  lots_datapath u_dp (.clk, .rst, .pair_we, .begin_we, .first_letter, .prev_letter,
    .next_letter, .pair_last, .cmd, .stat, .out_letter, .order_last, .input_fault);

`ifndef ASSERT_OFF
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_letter) && $stable(order_last)
      && $stable(input_fault));
  a_busy_stall: assert property (@(posedge clk) disable iff (rst) out_valid |-> in_stall);
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && order_last |=> !out_valid);
`endif
endmodule
`default_nettype wire
